// ----- design/rv32i_execute_core_defines.svh -----
// Assertion macros for the RV32I execute core.
`ifndef RV32I_EXECUTE_CORE_DEFINES_SVH
`define RV32I_EXECUTE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define RV_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RV_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RV_ASSERT(label, clk, rst_n, prop, msg)
`define RV_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- design/rvex_pkg.sv -----
// Package with opcodes, status codes and shared types of the RV32I execute core.
package rvex_pkg;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] F7_ALT    = 7'h20;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_WAIT = 3'd1;
  localparam logic [2:0] ST_ILL  = 3'd2;
  localparam logic [2:0] ST_MIS  = 3'd3;
  localparam logic [2:0] ST_ERR  = 3'd4;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic        action;
    logic [31:0] instr;
    logic [31:0] read_data;
    logic        mem_fault;
    logic        len_bad;
  } item_t;

  function automatic logic [31:0] swap16(input logic [31:0] v);
    return {16'h0, v[7:0], v[15:8]};
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// ----- design/rvex_front.sv -----
// Front part: accepts items, classifies them and holds them in a two-entry queue.
module rvex_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 action_i,
  input  logic [31:0]          instr_i,
  input  logic [31:0]          read_data_i,
  input  logic                 mem_fault_i,
  output logic                 q_valid_o,
  output rvex_pkg::item_t      q_item_o,
  input  logic                 q_pop_i
);
  import rvex_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  item_t      new_item;

  // Flag instruction words whose length encoding is not 32 bits.
  always_comb begin
    new_item.action    = action_i;
    new_item.instr     = instr_i;
    new_item.read_data = read_data_i;
    new_item.mem_fault = mem_fault_i;
    new_item.len_bad   = (instr_i[1:0] != 2'b11) || (instr_i[4:0] == 5'b11111);
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule

// ----- design/rvex_back.sv -----
// Back part: executes queued items against the register file and pc.
module rvex_back #(
  parameter int NUM_REGS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 big_endian_i,
  input  logic                 q_valid_i,
  input  rvex_pkg::item_t      q_item_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           status_o,
  output logic [31:0]          next_pc_o,
  output logic                 mem_valid_o,
  output logic                 mem_write_o,
  output logic [31:0]          mem_addr_o,
  output logic [1:0]           mem_size_o,
  output logic [31:0]          mem_wdata_o
);
  import rvex_pkg::*;

  logic [31:0] rf_q [1:NUM_REGS-1];
  logic [31:0] pc_q;
  logic        pend_q;
  logic [4:0]  ldest_q;
  logic [2:0]  lkind_q;
  logic        out_valid_q;

  logic [31:0] ins, a, b, immi, r, t, wval, pc_d, ldv;
  logic [6:0]  op, f7;
  logic [2:0]  f3, st;
  logic [4:0]  rd, rs1, rs2, wdst;
  logic        we, take, ok, mv, mw, set_pend, clr_pend;
  logic [31:0] ma, md;
  logic [1:0]  ms;
  logic [12:0] boff;
  logic [20:0] joff;
  logic [4:0]  sh;
  logic [31:0] bop;
  logic        fire;

  function automatic logic [31:0] rreg_f(input logic [4:0] i,
                                        input logic [31:0] v);
    return (i == 5'd0 || 32'(i) >= NUM_REGS) ? 32'h0 : v;
  endfunction

  assign ins  = q_item_i.instr;
  assign op   = ins[6:0];
  assign rd   = ins[11:7];
  assign f3   = ins[14:12];
  assign rs1  = ins[19:15];
  assign rs2  = ins[24:20];
  assign f7   = ins[31:25];
  assign a    = rreg_f(rs1, (32'(rs1) < NUM_REGS && rs1 != 5'd0) ? rf_q[rs1] : 32'h0);
  assign b    = rreg_f(rs2, (32'(rs2) < NUM_REGS && rs2 != 5'd0) ? rf_q[rs2] : 32'h0);
  assign immi = {{20{ins[31]}}, ins[31:20]};
  assign boff = {ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign joff = {ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign t    = (a + immi) & ~32'h1;

  // Output register is free when empty or being taken this cycle.
  assign fire    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = fire;

  // ALU for the register and immediate forms.
  always_comb begin
    bop = (op == OP_IMM) ? immi : b;
    sh  = bop[4:0];
    ok  = 1'b1;
    r   = 32'h0;
    case (f3)
      3'd0: begin
        if (op == OP_IMM || f7 == 7'd0) r = a + bop;
        else if (f7 == F7_ALT) r = a - bop;
        else ok = 1'b0;
      end
      3'd1: begin
        ok = (f7 == 7'd0);
        r  = a << sh;
      end
      3'd2: r = {31'h0, $signed(a) < $signed(bop)};
      3'd3: r = {31'h0, a < bop};
      3'd4: r = a ^ bop;
      3'd5: begin
        if (f7 == 7'd0) r = a >> sh;
        else if (f7 == F7_ALT) r = 32'($signed(a) >>> sh);
        else ok = 1'b0;
      end
      3'd6: r = a | bop;
      default: r = a & bop;
    endcase
    if (f3 != 3'd0 && f3 != 3'd1 && f3 != 3'd5 && op == OP_REG && f7 != 7'd0) ok = 1'b0;
  end

  // Load return data shaping.
  always_comb begin
    case (lkind_q)
      3'd0: ldv = {{24{q_item_i.read_data[7]}}, q_item_i.read_data[7:0]};
      3'd1: begin
        ldv = big_endian_i ? swap16(q_item_i.read_data)
                           : {16'h0, q_item_i.read_data[15:0]};
        ldv = {{16{ldv[15]}}, ldv[15:0]};
      end
      3'd4: ldv = {24'h0, q_item_i.read_data[7:0]};
      3'd5: ldv = big_endian_i ? swap16(q_item_i.read_data)
                               : {16'h0, q_item_i.read_data[15:0]};
      default: ldv = big_endian_i ? swap32(q_item_i.read_data) : q_item_i.read_data;
    endcase
  end

  // Execute one item.
  always_comb begin
    st = ST_OK; pc_d = pc_q; we = 1'b0; wdst = rd; wval = 32'h0;
    mv = 1'b0; mw = 1'b0; ma = 32'h0; ms = 2'd0; md = 32'h0;
    set_pend = 1'b0; clr_pend = 1'b0; take = 1'b0;
    if (q_item_i.action) begin
      if (!pend_q) st = ST_ERR;
      else begin
        clr_pend = 1'b1;
        if (q_item_i.mem_fault) st = ST_ERR;
        else begin
          we = 1'b1; wdst = ldest_q; wval = ldv; pc_d = pc_q + 32'd4;
        end
      end
    end else if (pend_q || q_item_i.mem_fault || q_item_i.len_bad) begin
      st = ST_ERR;
    end else begin
      case (op)
        OP_LUI: begin
          we = 1'b1; wval = {ins[31:12], 12'h0}; pc_d = pc_q + 32'd4;
        end
        OP_AUIPC: begin
          we = 1'b1; wval = pc_q + {ins[31:12], 12'h0}; pc_d = pc_q + 32'd4;
        end
        OP_JAL: begin
          we = 1'b1; wval = pc_q + 32'd4; pc_d = pc_q + {{11{joff[20]}}, joff};
        end
        OP_JALR: begin
          if (f3 != 3'd0) st = ST_ILL;
          else if (t[1]) st = ST_MIS;
          else begin
            we = 1'b1; wval = pc_q + 32'd4; pc_d = t;
          end
        end
        OP_BRANCH: begin
          case (f3)
            3'd0: take = (a == b);
            3'd1: take = (a != b);
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = !($signed(a) < $signed(b));
            3'd6: take = a < b;
            3'd7: take = a >= b;
            default: st = ST_ILL;
          endcase
          if (st == ST_OK) pc_d = take ? pc_q + {{19{boff[12]}}, boff} : pc_q + 32'd4;
        end
        OP_LOAD: begin
          if (f3 == 3'd3 || f3 > 3'd5) st = ST_ILL;
          else begin
            mv = 1'b1; ma = a + immi; ms = f3[1:0]; set_pend = 1'b1; st = ST_WAIT;
          end
        end
        OP_STORE: begin
          if (f3 > 3'd2) st = ST_ILL;
          else begin
            mv = 1'b1; mw = 1'b1; ms = f3[1:0];
            ma = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
            if (f3 == 3'd0) md = {24'h0, b[7:0]};
            else if (f3 == 3'd1) md = big_endian_i ? swap16(b) : {16'h0, b[15:0]};
            else md = big_endian_i ? swap32(b) : b;
            pc_d = pc_q + 32'd4;
          end
        end
        OP_IMM, OP_REG: begin
          if (!ok) st = ST_ILL;
          else begin
            we = 1'b1; wval = r; pc_d = pc_q + 32'd4;
          end
        end
        default: st = ST_ILL;
      endcase
    end
  end

  // Register file write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i < NUM_REGS; i++) rf_q[i] <= 32'h0;
    end else if (fire && we && wdst != 5'd0 && 32'(wdst) < NUM_REGS) begin
      rf_q[wdst] <= wval;
    end
  end

  // Architectural control state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= 32'h0;
      pend_q      <= 1'b0;
      ldest_q     <= 5'd0;
      lkind_q     <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        pc_q <= pc_d;
        if (set_pend) begin
          pend_q <= 1'b1; ldest_q <= rd; lkind_q <= f3;
        end else if (clr_pend) begin
          pend_q <= 1'b0;
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_o    <= st;
      next_pc_o   <= pc_d;
      mem_valid_o <= mv;
      mem_write_o <= mw;
      mem_addr_o  <= ma;
      mem_size_o  <= ms;
      mem_wdata_o <= md;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/rv32i_execute_core.sv -----
// A result passes through the queue, then the result register, before it is offered.
// Throughput: one item per cycle while out_stall_i is low; a load needs a second item carrying its data.
// The back part's execute loop over registers and pc sets the rate.
// Reset clears the register file, pc, pending load state, queue and big_endian.
// Top level of the RV32I execute core.
`include "rv32i_execute_core_defines.svh"
module rv32i_execute_core #(
  parameter int NUM_REGS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] instr_i,
  input  logic [31:0] read_data_i,
  input  logic        mem_fault_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] next_pc_o,
  output logic        mem_valid_o,
  output logic        mem_write_o,
  output logic [31:0] mem_addr_o,
  output logic [1:0]  mem_size_o,
  output logic [31:0] mem_wdata_o
);
  import rvex_pkg::*;

  logic  big_endian_q;
  logic  q_valid, q_pop;
  item_t q_item;

  assign cfg_ready_o = 1'b1;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) big_endian_q <= 1'b0;
    else if (cfg_valid_i && cfg_ready_o) big_endian_q <= cfg_data_i;
  end

  rvex_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .instr_i,
    .read_data_i, .mem_fault_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  rvex_back #(.NUM_REGS(NUM_REGS)) u_back (
    .clk_i, .rst_ni, .big_endian_i(big_endian_q),
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_valid_o, .out_stall_i, .status_o, .next_pc_o, .mem_valid_o,
    .mem_write_o, .mem_addr_o, .mem_size_o, .mem_wdata_o
  );

  // The queue is only drained when it holds an item.
  `RV_ASSERT(a_pop_valid, clk_i, rst_ni, q_pop |-> q_valid, "pop from empty queue")
  // A memory request never comes with an illegal or error status.
  `RV_ASSERT(a_req_status, clk_i, rst_ni, (out_valid_o && mem_valid_o) |-> (status_o == ST_OK || status_o == ST_WAIT), "request with bad status")
  // A waiting status always carries a load request.
  `RV_ASSERT(a_wait_load, clk_i, rst_ni, (out_valid_o && status_o == ST_WAIT) |-> (mem_valid_o && !mem_write_o), "wait without load")
  // An offered status is always one of the defined codes.
  `RV_ASSERT_NEVER(a_status_range, clk_i, rst_ni, out_valid_o && (status_o > ST_ERR), "status out of range")

endmodule
